/* rtl/o3wo_pkg.sv */
package o3wo_pkg;

  localparam int SPEED_W = 16;
  localparam int POS_W   = 32;
  localparam int ANGLE_W = 32;
  localparam int DT_W    = 10;
  localparam int RAD_W   = 16;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = 64;

  localparam int DIV_N_W = 33;
  localparam int DIV_D_W = 18;

  localparam int COR_W     = 34;
  localparam int ATAN_W    = 30;
  localparam int COR_MAX   = 24;
  localparam int ATAN_IDX_W = 5;

  localparam logic [MUL_B_W-1:0] INV_SQRT3_Q16 = 26'd37837;
  localparam logic [MUL_B_W-1:0] YAW_GAIN_Q16  = 26'd43748177;
  localparam logic signed [COR_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [DIV_D_W-1:0] DEN_THREE    = 18'd3;
  localparam logic [DIV_D_W-1:0] DEN_THOUSAND = 18'd1000;
  localparam logic [DIV_N_W-1:0] HALF_THOUSAND = 33'd500;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd9830;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VX,
    ST_VY,
    ST_WZ,
    ST_YAW_DT,
    ST_YAW_GAIN,
    ST_CORDIC,
    ST_M_VXC,
    ST_M_VYS,
    ST_M_VXS,
    ST_M_VYC,
    ST_PX_MUL,
    ST_PX_DIV,
    ST_PY_MUL,
    ST_PY_DIV,
    ST_DONE
  } state_t;

  function automatic logic [ATAN_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] r;
    unique case (i)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2F9;
      5'd15: r = 30'h0000517C;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A2F;
      5'd19: r = 30'h00000517;
      5'd20: r = 30'h0000028B;
      5'd21: r = 30'h00000145;
      5'd22: r = 30'h000000A2;
      5'd23: r = 30'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [33:0] apply_sign(input logic neg,
                                                    input logic [32:0] mag);
    logic signed [33:0] m;
    m = $signed({1'b0, mag});
    return neg ? -m : m;
  endfunction

  function automatic logic signed [15:0] sat_speed(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = $signed(v[15:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_pos(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/omni3_wheel_odometry.sv */
// A clear transaction goes straight to the result stage; an update with
// 16 CORDIC stages runs nine multiplies, four divides and the CORDIC rotation
// one after another, then the result stage.
// Only one transaction is in flight at a time, since the bit-serial multiplier
// and divider are shared; a new transaction is taken while the previous result waits.
// Reset clears position, heading and the control state, and sets the radius to 9830.
module omni3_wheel_odometry #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,   // robot_radius
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,       // wheel_front_speed, wheel_left_speed,
                                      // wheel_right_speed, dt_ms, zero pad
  input  logic         s_tuser,       // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata        // pos_x, pos_y, heading, body_vx, body_vy,
                                      // body_wz
);

  o3wo_pkg::state_t state, state_next;
  logic pend, pend_next;

  logic [15:0]        radius;
  logic signed [15:0] w1, w2, w3;
  logic [9:0]         dt;
  logic signed [15:0] vx, vy, wz;
  logic [31:0]        yaw;
  logic signed [31:0] x_acc, y_acc;
  logic signed [47:0] vxw, vyw;
  logic [25:0]        p1;

  logic        mul_start, mul_done, div_start, div_done, cor_start, cor_done;
  logic        use_mul, use_div, use_cor, fin;
  o3wo_pkg::state_t after;
  logic [o3wo_pkg::MUL_A_W-1:0] mul_a;
  logic [o3wo_pkg::MUL_B_W-1:0] mul_b;
  logic [o3wo_pkg::MUL_P_W-1:0] prod;
  logic [o3wo_pkg::DIV_N_W-1:0] div_num, quot;
  logic [o3wo_pkg::DIV_D_W-1:0] div_den;
  logic signed [o3wo_pkg::COR_W-1:0] sn, cs;

  logic signed [18:0] n_vx;
  logic signed [17:0] sum3;
  logic signed [16:0] d_vy;
  logic [18:0] n_vx_mag;
  logic [17:0] sum3_mag;
  logic [16:0] d_vy_mag;
  logic [15:0] vx_mag, vy_mag, wz_mag, r_eff;
  logic [17:0] den3;
  logic [31:0] c_mag, s_mag;
  logic [46:0] vxw_mag, vyw_mag;
  logic        term_neg;
  logic signed [47:0] term;
  logic [63:0] rnd16;
  logic [31:0] yaw_d;
  logic signed [34:0] pos_sum;
  logic        pos_neg;
  logic signed [31:0] pos_base;

  always_comb begin
    n_vx     = (19'(w1) <<< 1) - 19'(w2) - 19'(w3);
    sum3     = 18'(w1) + 18'(w2) + 18'(w3);
    d_vy     = 17'(w2) - 17'(w3);
    n_vx_mag = n_vx[18] ? 19'(-n_vx) : 19'(n_vx);
    sum3_mag = sum3[17] ? 18'(-sum3) : 18'(sum3);
    d_vy_mag = d_vy[16] ? 17'(-d_vy) : 17'(d_vy);
    vx_mag   = vx[15] ? 16'(-vx) : 16'(vx);
    vy_mag   = vy[15] ? 16'(-vy) : 16'(vy);
    wz_mag   = wz[15] ? 16'(-wz) : 16'(wz);
    r_eff    = (radius == 16'd0) ? 16'd1 : radius;
    den3     = 18'({r_eff, 1'b0}) + 18'(r_eff);
    c_mag    = cs[o3wo_pkg::COR_W-1] ? 32'(-cs) : 32'(cs);
    s_mag    = sn[o3wo_pkg::COR_W-1] ? 32'(-sn) : 32'(sn);
    vxw_mag  = vxw[47] ? 47'(-vxw) : 47'(vxw);
    vyw_mag  = vyw[47] ? 47'(-vyw) : 47'(vyw);
    rnd16    = prod + 64'd32768;
    yaw_d    = rnd16[47:16];
  end

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    div_num  = '0;
    div_den  = o3wo_pkg::DEN_THREE;
    term_neg = 1'b0;
    unique case (state)
      o3wo_pkg::ST_VX: begin
        div_num = 33'(n_vx_mag) + 33'd1;
        div_den = o3wo_pkg::DEN_THREE;
      end
      o3wo_pkg::ST_VY: begin
        mul_a = 48'(d_vy_mag);
        mul_b = o3wo_pkg::INV_SQRT3_Q16;
      end
      o3wo_pkg::ST_WZ: begin
        div_num = (33'(sum3_mag) << 14) + 33'(den3 >> 1);
        div_den = den3;
      end
      o3wo_pkg::ST_YAW_DT: begin
        mul_a = 48'(wz_mag);
        mul_b = 26'(dt);
      end
      o3wo_pkg::ST_YAW_GAIN: begin
        mul_a = 48'(p1);
        mul_b = o3wo_pkg::YAW_GAIN_Q16;
      end
      o3wo_pkg::ST_M_VXC: begin
        mul_a    = 48'(c_mag);
        mul_b    = 26'(vx_mag);
        term_neg = vx[15] ^ cs[o3wo_pkg::COR_W-1];
      end
      o3wo_pkg::ST_M_VYS: begin
        mul_a    = 48'(s_mag);
        mul_b    = 26'(vy_mag);
        term_neg = vy[15] ^ sn[o3wo_pkg::COR_W-1];
      end
      o3wo_pkg::ST_M_VXS: begin
        mul_a    = 48'(s_mag);
        mul_b    = 26'(vx_mag);
        term_neg = vx[15] ^ sn[o3wo_pkg::COR_W-1];
      end
      o3wo_pkg::ST_M_VYC: begin
        mul_a    = 48'(c_mag);
        mul_b    = 26'(vy_mag);
        term_neg = vy[15] ^ cs[o3wo_pkg::COR_W-1];
      end
      o3wo_pkg::ST_PX_MUL: begin
        mul_a = 48'(vxw_mag);
        mul_b = 26'(dt);
      end
      o3wo_pkg::ST_PY_MUL: begin
        mul_a = 48'(vyw_mag);
        mul_b = 26'(dt);
      end
      o3wo_pkg::ST_PX_DIV, o3wo_pkg::ST_PY_DIV: begin
        div_num = 33'(prod[63:26]) + o3wo_pkg::HALF_THOUSAND;
        div_den = o3wo_pkg::DEN_THOUSAND;
      end
      default: begin
      end
    endcase
    term = term_neg ? -$signed({1'b0, prod[46:0]}) : $signed({1'b0, prod[46:0]});
    pos_neg  = (state == o3wo_pkg::ST_PX_DIV) ? vxw[47] : vyw[47];
    pos_base = (state == o3wo_pkg::ST_PX_DIV) ? x_acc : y_acc;
    pos_sum  = 35'(pos_base) + 35'(o3wo_pkg::apply_sign(pos_neg, quot));
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    use_mul    = 1'b0;
    use_div    = 1'b0;
    use_cor    = 1'b0;
    after      = o3wo_pkg::ST_IDLE;
    s_tready   = (state == o3wo_pkg::ST_IDLE);
    unique case (state)
      o3wo_pkg::ST_IDLE: begin
        pend_next = 1'b0;
        if (s_tvalid) begin
          state_next = s_tuser ? o3wo_pkg::ST_DONE : o3wo_pkg::ST_VX;
        end
      end
      o3wo_pkg::ST_VX:       begin use_div = 1'b1; after = o3wo_pkg::ST_VY;       end
      o3wo_pkg::ST_VY:       begin use_mul = 1'b1; after = o3wo_pkg::ST_WZ;       end
      o3wo_pkg::ST_WZ:       begin use_div = 1'b1; after = o3wo_pkg::ST_YAW_DT;   end
      o3wo_pkg::ST_YAW_DT:   begin use_mul = 1'b1; after = o3wo_pkg::ST_YAW_GAIN; end
      o3wo_pkg::ST_YAW_GAIN: begin use_mul = 1'b1; after = o3wo_pkg::ST_CORDIC;   end
      o3wo_pkg::ST_CORDIC:   begin use_cor = 1'b1; after = o3wo_pkg::ST_M_VXC;    end
      o3wo_pkg::ST_M_VXC:    begin use_mul = 1'b1; after = o3wo_pkg::ST_M_VYS;    end
      o3wo_pkg::ST_M_VYS:    begin use_mul = 1'b1; after = o3wo_pkg::ST_M_VXS;    end
      o3wo_pkg::ST_M_VXS:    begin use_mul = 1'b1; after = o3wo_pkg::ST_M_VYC;    end
      o3wo_pkg::ST_M_VYC:    begin use_mul = 1'b1; after = o3wo_pkg::ST_PX_MUL;   end
      o3wo_pkg::ST_PX_MUL:   begin use_mul = 1'b1; after = o3wo_pkg::ST_PX_DIV;   end
      o3wo_pkg::ST_PX_DIV:   begin use_div = 1'b1; after = o3wo_pkg::ST_PY_MUL;   end
      o3wo_pkg::ST_PY_MUL:   begin use_mul = 1'b1; after = o3wo_pkg::ST_PY_DIV;   end
      o3wo_pkg::ST_PY_DIV:   begin use_div = 1'b1; after = o3wo_pkg::ST_DONE;     end
      o3wo_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = o3wo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = o3wo_pkg::ST_IDLE;
      end
    endcase
    fin = pend && ((use_mul && mul_done) || (use_div && div_done) || (use_cor && cor_done));
    if (use_mul || use_div || use_cor) begin
      if (!pend) begin
        mul_start = use_mul;
        div_start = use_div;
        cor_start = use_cor;
        pend_next = 1'b1;
      end else if (fin) begin
        pend_next  = 1'b0;
        state_next = after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= o3wo_pkg::ST_IDLE;
      pend     <= 1'b0;
      radius   <= o3wo_pkg::RADIUS_RESET;
      yaw      <= '0;
      x_acc    <= '0;
      y_acc    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (cfg_wr_en) begin
        radius <= cfg_wr_data;
      end
      if (s_tvalid && s_tready && s_tuser) begin
        yaw   <= '0;
        x_acc <= '0;
        y_acc <= '0;
      end
      if (fin && state == o3wo_pkg::ST_YAW_GAIN) begin
        yaw <= yaw + (wz[15] ? -yaw_d : yaw_d);
      end
      if (fin && state == o3wo_pkg::ST_PX_DIV) begin
        x_acc <= o3wo_pkg::sat_pos(pos_sum);
      end
      if (fin && state == o3wo_pkg::ST_PY_DIV) begin
        y_acc <= o3wo_pkg::sat_pos(pos_sum);
      end
      if (state == o3wo_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      w1 <= $signed(s_tdata[15:0]);
      w2 <= $signed(s_tdata[31:16]);
      w3 <= $signed(s_tdata[47:32]);
      dt <= s_tdata[57:48];
      if (s_tuser) begin
        vx <= '0;
        vy <= '0;
        wz <= '0;
      end
    end
    if (fin) begin
      unique case (state)
        o3wo_pkg::ST_VX: vx <= o3wo_pkg::sat_speed(o3wo_pkg::apply_sign(n_vx[18], quot));
        o3wo_pkg::ST_VY: vy <= o3wo_pkg::sat_speed(
                                 o3wo_pkg::apply_sign(d_vy[16], 33'(rnd16[32:16])));
        o3wo_pkg::ST_WZ: wz <= o3wo_pkg::sat_speed(o3wo_pkg::apply_sign(sum3[17], quot));
        o3wo_pkg::ST_YAW_DT: p1 <= prod[25:0];
        o3wo_pkg::ST_M_VXC: vxw <= term;
        o3wo_pkg::ST_M_VYS: vxw <= vxw - term;
        o3wo_pkg::ST_M_VXS: vyw <= term;
        o3wo_pkg::ST_M_VYC: vyw <= vyw + term;
        default: begin
        end
      endcase
    end
    if (state == o3wo_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {wz, vy, vx, yaw[31:16], y_acc, x_acc};
    end
  end

  o3wo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  o3wo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  o3wo_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .ang   (yaw),
    .sin_o (sn),
    .cos_o (cs),
    .done  (cor_done)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again straight after a transaction");

  a_one_unit_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_done, div_done, cor_done}))
    else $error("more than one arithmetic unit finished in the same cycle");

  a_heading_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tdata[79:64] == yaw[31:16]))
    else $error("reported heading differs from the heading register");

  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> (state == o3wo_pkg::ST_DONE))
    else $error("clear transaction did not go straight to the result stage");

endmodule

/* rtl/o3wo_mul.sv */
module o3wo_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [o3wo_pkg::MUL_A_W-1:0] a,
  input  logic [o3wo_pkg::MUL_B_W-1:0] b,
  output logic [o3wo_pkg::MUL_P_W-1:0] prod,
  output logic                         done
);

  localparam int CNT_W = $clog2(o3wo_pkg::MUL_B_W);

  logic                         busy;
  logic [CNT_W-1:0]             cnt;
  logic [o3wo_pkg::MUL_P_W-1:0] ash;
  logic [o3wo_pkg::MUL_B_W-1:0] bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(o3wo_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One multiplier bit per cycle, least significant first.
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      ash  <= o3wo_pkg::MUL_P_W'(a);
      bsh  <= b;
    end else if (busy) begin
      if (bsh[0]) begin
        prod <= prod + ash;
      end
      ash <= ash << 1;
      bsh <= bsh >> 1;
    end
  end

endmodule

/* rtl/o3wo_div.sv */
module o3wo_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [o3wo_pkg::DIV_N_W-1:0] num,
  input  logic [o3wo_pkg::DIV_D_W-1:0] den,
  output logic [o3wo_pkg::DIV_N_W-1:0] quot,
  output logic                         done
);

  localparam int CNT_W = $clog2(o3wo_pkg::DIV_N_W);

  logic                         busy;
  logic [CNT_W-1:0]             cnt;
  logic [o3wo_pkg::DIV_D_W-1:0] rem;
  logic [o3wo_pkg::DIV_D_W-1:0] dd;
  logic [o3wo_pkg::DIV_D_W:0]   trial;
  logic                         fits;

  always_comb begin
    trial = {rem, quot[o3wo_pkg::DIV_N_W-1]};
    fits  = (trial >= {1'b0, dd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(o3wo_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division: the quotient bits shift in behind the dividend bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dd   <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= o3wo_pkg::DIV_D_W'(trial - {1'b0, dd});
      end else begin
        rem <= o3wo_pkg::DIV_D_W'(trial);
      end
      quot <= {quot[o3wo_pkg::DIV_N_W-2:0], fits};
    end
  end

endmodule

/* rtl/o3wo_cordic.sv */
module o3wo_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [o3wo_pkg::ANGLE_W-1:0]      ang,
  output logic signed [o3wo_pkg::COR_W-1:0] sin_o,
  output logic signed [o3wo_pkg::COR_W-1:0] cos_o,
  output logic                              done
);

  localparam int NUM   = (STAGES > o3wo_pkg::COR_MAX) ? o3wo_pkg::COR_MAX : STAGES;
  localparam int CNT_W = $clog2(NUM);

  logic                              busy;
  logic [CNT_W-1:0]                  idx;
  logic                              neg;
  logic signed [o3wo_pkg::COR_W-1:0] x;
  logic signed [o3wo_pkg::COR_W-1:0] y;
  logic signed [o3wo_pkg::COR_W-1:0] z;
  logic signed [o3wo_pkg::COR_W-1:0] xs;
  logic signed [o3wo_pkg::COR_W-1:0] ys;
  logic signed [o3wo_pkg::COR_W-1:0] at;
  logic                              fold;
  logic [o3wo_pkg::ANGLE_W-1:0]      ang_f;

  always_comb begin
    fold  = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    ang_f = {ang[31] ^ fold, ang[30:0]};
    xs    = x >>> idx;
    ys    = y >>> idx;
    at    = $signed({4'b0000, o3wo_pkg::atan_val(o3wo_pkg::ATAN_IDX_W'(idx))});
  end

  assign cos_o = neg ? -x : x;
  assign sin_o = neg ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == CNT_W'(NUM - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One rotation step per cycle on the folded angle.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= fold;
      x   <= o3wo_pkg::CORDIC_X0;
      y   <= '0;
      z   <= o3wo_pkg::COR_W'($signed(ang_f));
    end else if (busy) begin
      if (!z[o3wo_pkg::COR_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule
